[rtl/hfbs_pkg.sv]
// ----------------------------------------------------------------------------
// hfbs_pkg
// shared types and constants of the hdlc frame bit stuffer
// ----------------------------------------------------------------------------
package hfbs_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int FLAG_CNT_W = 6;

  localparam logic [1:0] MODE_START    = 2'd0;
  localparam logic [1:0] MODE_DATA     = 2'd1;
  localparam logic [1:0] MODE_END_MORE = 2'd2;
  localparam logic [1:0] MODE_END_LAST = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSTAMBLE = 2'd1;

  localparam logic [FLAG_CNT_W-1:0] FLAG_MAX      = 6'd60;
  localparam logic [FLAG_CNT_W-1:0] PREAMBLE_RST  = 6'd30;
  localparam logic [FLAG_CNT_W-1:0] POSTAMBLE_RST = 6'd2;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  RUN_MASK  = 8'h7C;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_FCS_LO,
    SEL_FCS_HI,
    SEL_FLAG
  } byte_sel_t;

  typedef struct packed {
    logic      accept;
    logic [1:0] mode;
    logic      load;
    byte_sel_t sel;
    logic      step;
    logic      flush;
  } dp_cmd_t;

  typedef struct packed {
    logic byte_end;
    logic flush_done;
  } dp_stat_t;

endpackage

[rtl/hfbs_dp.sv]
// ----------------------------------------------------------------------------
// hfbs_dp
// bit-serial datapath: crc, zero stuffing, byte packing and output register
// ----------------------------------------------------------------------------
module hfbs_dp (
  input  logic              clk,
  input  logic              rst,
  input  hfbs_pkg::dp_cmd_t cmd,
  input  logic [7:0]        data_byte,
  output hfbs_pkg::dp_stat_t stat,
  output logic [7:0]        out_byte,
  output logic              run_last,
  output logic              out_valid,
  input  logic              out_ready
);
  import hfbs_pkg::*;

  logic [7:0]  data_r;
  logic [15:0] fcs;
  logic [15:0] crc;
  logic [7:0]  cur;
  logic        is_flag;
  logic        crc_en;
  logic [2:0]  bit_idx;
  logic [7:0]  shifter;
  logic [2:0]  count;
  logic [7:0]  pend;
  logic        pend_v;

  logic        stuff;
  logic        line_bit;
  logic [7:0]  pushed;
  logic [2:0]  count_next;
  logic        full;
  logic        out_free;
  logic        advance;
  logic        fb;
  logic [15:0] crc_next;
  logic        flush_move;
  logic        out_load;

  always_comb begin
    stuff      = (!is_flag || (bit_idx == 3'd0)) && ((shifter & RUN_MASK) == RUN_MASK);
    line_bit   = stuff ? 1'b0 : cur[bit_idx];
    pushed     = shifter | {line_bit, 7'd0};
    count_next = count + 3'd1;
    full       = (count_next == 3'd0);
    out_free   = !out_valid || out_ready;
    advance    = cmd.step && (!full || !pend_v || out_free);
    fb         = crc[0] ^ line_bit;
    crc_next   = {1'b0, crc[15:1]} ^ (fb ? CRC_POLY : 16'd0);
    flush_move = cmd.flush && pend_v && out_free;
    out_load   = (advance && full && pend_v) || flush_move;
    stat.byte_end   = advance && !stuff && (bit_idx == 3'd7);
    stat.flush_done = !pend_v || out_free;
  end

  // control state and the model's line state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc       <= CRC_INIT;
      shifter   <= 8'd0;
      count     <= 3'd0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
      bit_idx   <= 3'd0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.accept && (cmd.mode != MODE_DATA)) begin
        crc <= CRC_INIT;
      end
      if (cmd.load) begin
        bit_idx <= 3'd0;
      end
      if (advance) begin
        shifter <= {1'b0, pushed[7:1]};
        count   <= count_next;
        if (full) begin
          pend_v <= 1'b1;
        end
        if (!stuff) begin
          bit_idx <= bit_idx + 3'd1;
          if (crc_en) begin
            crc <= crc_next;
          end
        end
      end
      if (flush_move) begin
        pend_v <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      data_r <= data_byte;
      if (cmd.mode == MODE_END_MORE || cmd.mode == MODE_END_LAST) begin
        fcs <= ~crc;
      end
    end
    if (cmd.load) begin
      unique case (cmd.sel)
        SEL_DATA:   cur <= data_r;
        SEL_FCS_LO: cur <= fcs[7:0];
        SEL_FCS_HI: cur <= fcs[15:8];
        SEL_FLAG:   cur <= FLAG_BYTE;
        default:    cur <= FLAG_BYTE;
      endcase
      is_flag <= (cmd.sel == SEL_FLAG);
      crc_en  <= (cmd.sel == SEL_DATA);
    end
    if (advance && full) begin
      if (pend_v) begin
        out_byte <= pend;
        run_last <= 1'b0;
      end
      pend <= pushed;
    end
    if (flush_move) begin
      out_byte <= pend;
      run_last <= 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.step && full && pend_v && !out_free |=> $stable(shifter) && $stable(count))
    else $error("line state moved while output was blocked");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    flush_move |=> out_valid && run_last && !pend_v)
    else $error("flush did not present last beat");

  a_crc_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && (cmd.mode != MODE_DATA) |=> crc == CRC_INIT)
    else $error("crc not restarted");

endmodule

[rtl/hfbs_ctrl.sv]
// ----------------------------------------------------------------------------
// hfbs_ctrl
// command sequencer: byte order per command, flag counts, config registers
// ----------------------------------------------------------------------------
module hfbs_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     mode,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hfbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfbs_pkg::FLAG_CNT_W-1:0] cfg_data,
  output hfbs_pkg::dp_cmd_t              cmd,
  input  hfbs_pkg::dp_stat_t             stat
);
  import hfbs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEND,
    ST_FLUSH
  } state_t;

  state_t                state;
  byte_sel_t             phase;
  logic [FLAG_CNT_W-1:0] flag_cnt;
  logic [FLAG_CNT_W-1:0] preamble;
  logic [FLAG_CNT_W-1:0] postamble;
  logic [FLAG_CNT_W-1:0] cfg_sat;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_sat   = (cfg_data > FLAG_MAX) ? FLAG_MAX : cfg_data;

  always_comb begin
    cmd.accept = in_valid && (state == ST_IDLE);
    cmd.mode   = mode;
    cmd.load   = (state == ST_LOAD);
    cmd.sel    = phase;
    cmd.step   = (state == ST_SEND);
    cmd.flush  = (state == ST_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= SEL_DATA;
      flag_cnt  <= '0;
      preamble  <= PREAMBLE_RST;
      postamble <= POSTAMBLE_RST;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_PREAMBLE:  preamble  <= cfg_sat;
          REG_POSTAMBLE: postamble <= cfg_sat;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            unique case (mode)
              MODE_START: begin
                phase    <= SEL_FLAG;
                flag_cnt <= preamble;
                state    <= (preamble == '0) ? ST_FLUSH : ST_LOAD;
              end
              MODE_DATA: begin
                phase <= SEL_DATA;
                state <= ST_LOAD;
              end
              MODE_END_MORE: begin
                phase    <= SEL_FCS_LO;
                flag_cnt <= FLAG_CNT_W'(1);
                state    <= ST_LOAD;
              end
              default: begin
                phase    <= SEL_FCS_LO;
                flag_cnt <= postamble;
                state    <= ST_LOAD;
              end
            endcase
          end
        end
        ST_LOAD: state <= ST_SEND;
        ST_SEND: begin
          if (stat.byte_end) begin
            unique case (phase)
              SEL_DATA: state <= ST_FLUSH;
              SEL_FCS_LO: begin
                phase <= SEL_FCS_HI;
                state <= ST_LOAD;
              end
              SEL_FCS_HI: begin
                phase <= SEL_FLAG;
                state <= (flag_cnt == '0) ? ST_FLUSH : ST_LOAD;
              end
              default: begin
                flag_cnt <= flag_cnt - FLAG_CNT_W'(1);
                state    <= (flag_cnt == FLAG_CNT_W'(1)) ? ST_FLUSH : ST_LOAD;
              end
            endcase
          end
        end
        ST_FLUSH: begin
          if (stat.flush_done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_step_only_send: assert property (@(posedge clk) disable iff (rst)
    stat.byte_end |-> state == ST_SEND)
    else $error("byte end outside send");

  a_flag_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEND && phase == SEL_FLAG |-> flag_cnt != '0)
    else $error("sending flag with empty count");

  a_load_to_send: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |=> state == ST_SEND && $stable(phase))
    else $error("load not followed by send");

endmodule

[rtl/hdlc_frame_bit_stuffer_top.sv]
// ----------------------------------------------------------------------------
// hdlc_frame_bit_stuffer_top
// hdlc framer: flags, crc-16 fcs, zero-bit stuffing, packed line bytes
// ----------------------------------------------------------------------------
// channel   dir  signals                          content
// s_*       in   s_tvalid s_tready s_tdata s_tuser  command beat
// m_*       out  m_tvalid m_tready m_tdata m_tlast  packed line byte
// cfg_*     in   cfg_valid cfg_ready cfg_index cfg_data  flag count write
//
// one line bit per cycle from a bit-serial shifter while sending and not held by
// the output; each frame byte is loaded, then shifted out with one extra zero per stuff
// a command is accepted, sends its bytes, then flushes the last beat;
// the flush waits while the output register is held
// an output beat waits in a pending stage and an output register
// a stalled m_tready holds the shifter only when both are full
// synchronous reset, no clearing pass
module hdlc_frame_bit_stuffer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // data_byte
  input  logic [1:0]                      s_tuser,   // mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // out_byte
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hfbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hfbs_pkg::FLAG_CNT_W-1:0] cfg_data
);
  import hfbs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  hfbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .mode      (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  hfbs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (s_tdata),
    .stat      (stat),
    .out_byte  (m_tdata),
    .run_last  (m_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

endmodule
